@@ rtl/percent_codec_defines.svh @@
// Assertion macros shared by the percent codec RTL.
`ifndef PERCENT_CODEC_DEFINES_SVH
`define PERCENT_CODEC_DEFINES_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define PC_ASSERT_HOLD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property whose consequent must hold in the cycle after the antecedent.
`define PC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PC_ASSERT_HOLD(label, prop, msg)
`define PC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/pc_pkg.sv @@
// Shared types, constants and character helpers of the percent codec.
`default_nettype none
package pc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  // One classified item: up to three result bytes, sent b0 first.
  typedef struct packed {
    logic [1:0] cnt;
    logic       last;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Letters, digits and underscore pass through the encoder unchanged.
  function automatic logic is_plain(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
  endfunction

  // Digits map to their low nibble; letters of either case to nibble plus nine.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
  endfunction

endpackage
`default_nettype wire

@@ rtl/pc_in_if.sv @@
// Input item channel of the percent codec.
`default_nettype none
interface pc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

@@ rtl/pc_out_if.sv @@
// Result item channel of the percent codec.
`default_nettype none
interface pc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

@@ rtl/pc_queue.sv @@
// Small job queue between the classifier and the serializer.
`default_nettype none
module pc_queue #(
  parameter int DEPTH = pc_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  pc_pkg::job_t     push_job,
  input  wire logic        pop,
  output pc_pkg::job_t     head_job,
  output logic             head_valid,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pc_pkg::job_t  slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head_job   = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == FULL_CNT);

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pc_front.sv @@
// Front end: accepts input items, tracks escape state and classifies each item.
`default_nettype none
`include "percent_codec_defines.svh"
module pc_front (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_we,
  input  wire logic    cfg_wdata,
  pc_in_if.sink        in_ch,
  input  wire logic    queue_full,
  output logic         push,
  output pc_pkg::job_t push_job
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  logic       mode_r, mode_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       b_hex;
  logic       idle_emit;
  logic [7:0] decoded;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign last        = in_ch.in_last;
  assign b_hex       = pc_pkg::is_hex(b);
  // A percent sign that is not the final byte opens an escape and is held back.
  assign idle_emit   = !((b == pc_pkg::CHAR_PERCENT) && !last);
  assign decoded     = {pc_pkg::hex_val(held_r), pc_pkg::hex_val(b)};

  // Classification of the incoming item and next escape state.
  always_comb begin
    push_job      = '0;
    push_job.last = last;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    mode_nxt      = mode_r;
    if (mode_r == pc_pkg::MODE_ENCODE) begin
      if (pc_pkg::is_plain(b)) begin
        push_job.cnt = 2'd1;
        push_job.b0  = b;
      end else begin
        push_job.cnt = 2'd3;
        push_job.b0  = pc_pkg::CHAR_PERCENT;
        push_job.b1  = pc_pkg::hex_char(b[7:4]);
        push_job.b2  = pc_pkg::hex_char(b[3:0]);
      end
    end else begin
      case (phase_r)
        PH_PCT: begin
          if (b_hex && !last) begin
            push_job.cnt = 2'd0;
            phase_nxt    = PH_DIGIT;
            held_nxt     = b;
          end else begin
            push_job.b0  = pc_pkg::CHAR_PERCENT;
            push_job.b1  = b;
            push_job.cnt = idle_emit ? 2'd2 : 2'd1;
            phase_nxt    = idle_emit ? PH_IDLE : PH_PCT;
          end
        end
        PH_DIGIT: begin
          if (b_hex) begin
            push_job.cnt = 2'd1;
            push_job.b0  = decoded;
            phase_nxt    = PH_IDLE;
          end else begin
            push_job.b0  = pc_pkg::CHAR_PERCENT;
            push_job.b1  = held_r;
            push_job.b2  = b;
            push_job.cnt = idle_emit ? 2'd3 : 2'd2;
            phase_nxt    = idle_emit ? PH_IDLE : PH_PCT;
          end
        end
        default: begin
          push_job.b0  = b;
          push_job.cnt = idle_emit ? 2'd1 : 2'd0;
          phase_nxt    = idle_emit ? PH_IDLE : PH_PCT;
        end
      endcase
    end
    if (!accept) begin
      phase_nxt = phase_r;
      held_nxt  = held_r;
    end
    // A mode write drops any pending escape.
    if (cfg_we) begin
      mode_nxt  = cfg_wdata;
      phase_nxt = PH_IDLE;
      held_nxt  = '0;
    end
  end

  // Items that produce no result bytes never enter the queue.
  assign push = accept && (push_job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pc_pkg::MODE_ENCODE;
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  `PC_ASSERT_HOLD(a_pending_only_decode, (phase_r == PH_IDLE) || (mode_r == pc_pkg::MODE_DECODE), "escape pending in encode mode")
  `PC_ASSERT_NEXT(a_cfg_clears, cfg_we, (phase_r == PH_IDLE) && (held_r == 8'h00), "mode write left escape state")
  `PC_ASSERT_HOLD(a_held_is_hex, (phase_r != PH_DIGIT) || pc_pkg::is_hex(held_r), "held digit is not hex")

endmodule
`default_nettype wire

@@ rtl/pc_back.sv @@
// Back end: serializes queued jobs into result items through an output register.
`default_nettype none
`include "percent_codec_defines.svh"
module pc_back (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  pc_pkg::job_t head_job,
  input  wire logic    head_valid,
  output logic         pop,
  pc_out_if.source     out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       load;
  logic       final_byte;
  logic [7:0] sel_byte;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  // The output register takes a new byte when empty or being drained.
  assign load       = !out_valid_r || out_ch.ready;
  assign final_byte = (idx_r == head_job.cnt - 2'd1);
  assign pop        = load && head_valid && final_byte;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head_job.b0;
      2'd1:    sel_byte = head_job.b1;
      default: sel_byte = head_job.b2;
    endcase
  end

  // Step through the bytes of the head job, one per cycle unless the output stalls.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_byte_nxt = sel_byte;
        out_last_nxt = head_job.last && final_byte;
        idx_nxt      = final_byte ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  `PC_ASSERT_HOLD(a_mid_job_head, (idx_r == 2'd0) || (head_valid && (idx_r < head_job.cnt)), "partial job lost its queue head")
  `PC_ASSERT_HOLD(a_pop_valid, !pop || head_valid, "pop from empty queue")
  `PC_ASSERT_NEXT(a_load_shows, load && head_valid, out_valid_r, "loaded byte not presented")

endmodule
`default_nettype wire

@@ rtl/percent_codec.sv @@
// Top level of the percent codec: classifier, job queue and serializer.
//
//   channel   direction   payload               handshake
//   in_ch     sink        in_byte[8], in_last   valid / ready
//   out_ch    source      out_byte[8], out_last valid / ready
//   cfg       write only  cfg_wdata[1] (mode)   cfg_we
//
// Each item yields zero to three result bytes; the serializer sends one byte
// per cycle unless out_ch stalls, and an encoded escape is sent as three bytes.
// An item is accepted whenever the job queue has room; its result bytes pass
// through the job queue and then the output register before they are presented.
// Synchronous reset clears the queue, the output register and selects encode.
// An output stall fills the queue, which then holds in_ch.ready low.
`default_nettype none
module percent_codec #(
  parameter int QUEUE_DEPTH = pc_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  pc_in_if.sink     in_ch,
  pc_out_if.source  out_ch
);

  pc_pkg::job_t push_job;
  pc_pkg::job_t head_job;
  logic         push;
  logic         pop;
  logic         head_valid;
  logic         queue_full;

  pc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  pc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  pc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
